>>> sv/qse_pkg.sv
// Shared types, constants and command codes for the quicksort engine.
package qse_pkg;

  // Default sizing of the element store and of one element.
  localparam int DEPTH_DEF      = 1024;
  localparam int DATA_WIDTH_DEF = 32;

  // Width of the value fields on the channels.
  localparam int VALUE_W = 32;

  // Action codes carried on the request channel.
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_FETCH = 1'b1;

  // One request word.
  typedef struct packed {
    logic                      action;
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } req_t;

  // One response word.
  typedef struct packed {
    logic signed [VALUE_W-1:0] value_res;
    logic                      last_res;
  } rsp_t;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FETCH,
    ST_INIT,
    ST_POP,
    ST_RANGE,
    ST_PIVOT,
    ST_SCAN,
    ST_CMP,
    ST_SW1,
    ST_SW2,
    ST_FIN1,
    ST_FIN2,
    ST_PUSH_HI,
    ST_PUSH_LO
  } state_t;

  // Datapath operations issued by the controller, one per cycle.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_FETCH,
    OP_FETCH_OUT,
    OP_SORT_INIT,
    OP_POP,
    OP_RANGE,
    OP_PIVOT,
    OP_SCAN_RD,
    OP_FIN_RD,
    OP_CMP,
    OP_SW1,
    OP_SW2,
    OP_FIN1,
    OP_FIN2,
    OP_PUSH_HI,
    OP_PUSH_LO
  } dp_op_t;

  // Command from controller to datapath.
  typedef struct packed {
    dp_op_t op;
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic fetch_pending;
    logic stack_empty;
    logic scan_done;
    logic le;
    logic rsp_valid;
  } status_t;

endpackage

>>> sv/qse_datapath.sv
// Datapath of the quicksort engine: element store, range stack, pointers and output register.
module qse_datapath #(
  parameter int DEPTH      = qse_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = qse_pkg::DATA_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  qse_pkg::req_t    req,
  input  qse_pkg::cmd_t    cmd,
  output qse_pkg::status_t status,
  output qse_pkg::rsp_t    rsp,
  output logic             rsp_valid,
  input  logic             rsp_ready
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int VW = qse_pkg::VALUE_W;

  // Storage.
  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [2*IW-1:0]       stk [DEPTH];

  // Control registers.
  logic [CW-1:0] count;
  logic [CW-1:0] rp;
  logic [CW-1:0] sp;
  logic          draining;

  // Partition registers and read data.
  logic [IW-1:0]         lo;
  logic [IW-1:0]         hi;
  logic [IW-1:0]         j;
  logic [IW-1:0]         st;
  logic [DATA_WIDTH-1:0] pivot;
  logic [DATA_WIDTH-1:0] rd0;
  logic [DATA_WIDTH-1:0] rd1;
  logic [2*IW-1:0]       stk_rd;
  logic                  last_pend;

  // Memory port controls.
  logic                  we;
  logic [IW-1:0]         wa;
  logic [DATA_WIDTH-1:0] wd;
  logic                  re0;
  logic [IW-1:0]         ra0;
  logic                  re1;
  logic [IW-1:0]         ra1;
  logic                  swe;
  logic [IW-1:0]         swa;
  logic [2*IW-1:0]       swd;
  logic                  sre;
  logic [IW-1:0]         sra;

  // Derived values.
  logic [DATA_WIDTH-1:0] in_elem;
  logic [VW-1:0]         out_val;
  logic [CW-1:0]         eff_count;
  logic                  load_room;
  logic [CW-1:0]         cnt_m1;
  logic [CW-1:0]         sp_m1;
  logic [CW-1:0]         rp_p1;
  logic [IW:0]           st_p1;
  logic [IW:0]           lo_p1;
  logic [IW-1:0]         st_m1;
  logic                  sp_room;
  logic                  push_hi_ok;
  logic                  push_lo_ok;
  logic [IW-1:0]         stk_lo;
  logic [IW-1:0]         stk_hi;

  // Conversion between the channel value and the stored element.
  generate
    if (DATA_WIDTH < VW) begin : g_narrow
      assign in_elem = req.value[DATA_WIDTH-1:0];
      assign out_val = {{(VW-DATA_WIDTH){rd0[DATA_WIDTH-1]}}, rd0};
    end else if (DATA_WIDTH == VW) begin : g_equal
      assign in_elem = req.value;
      assign out_val = rd0;
    end else begin : g_wide
      assign in_elem = {{(DATA_WIDTH-VW){1'b0}}, req.value};
      assign out_val = rd0[VW-1:0];
    end
  endgenerate

  // A load after draining starts a fresh set at index zero.
  assign eff_count  = draining ? '0 : count;
  assign load_room  = eff_count < CW'(DEPTH);
  assign cnt_m1     = count - CW'(1);
  assign sp_m1      = sp - CW'(1);
  assign rp_p1      = rp + CW'(1);
  assign st_p1      = {1'b0, st} + (IW+1)'(1);
  assign lo_p1      = {1'b0, lo} + (IW+1)'(1);
  assign st_m1      = st - IW'(1);
  assign sp_room    = sp < CW'(DEPTH);
  assign push_hi_ok = (st_p1 < {1'b0, hi}) && sp_room;
  assign push_lo_ok = (lo_p1 < {1'b0, st}) && sp_room;
  assign stk_lo     = stk_rd[2*IW-1:IW];
  assign stk_hi     = stk_rd[IW-1:0];

  // Status back to the controller.
  assign status.fetch_pending = draining && (rp < count);
  assign status.stack_empty   = (sp == '0);
  assign status.scan_done     = (j == hi);
  assign status.le            = $signed(rd0) <= $signed(pivot);
  assign status.rsp_valid     = rsp_valid;

  // Memory port selection for each operation.
  always_comb begin
    we  = 1'b0;
    wa  = '0;
    wd  = '0;
    re0 = 1'b0;
    ra0 = '0;
    re1 = 1'b0;
    ra1 = '0;
    swe = 1'b0;
    swa = sp[IW-1:0];
    swd = '0;
    sre = 1'b0;
    sra = sp_m1[IW-1:0];
    unique case (cmd.op)
      qse_pkg::OP_LOAD: begin
        we = load_room;
        wa = eff_count[IW-1:0];
        wd = in_elem;
      end
      qse_pkg::OP_FETCH: begin
        re0 = 1'b1;
        ra0 = rp[IW-1:0];
      end
      qse_pkg::OP_SORT_INIT: begin
        swe = count >= CW'(2);
        swa = '0;
        swd = {IW'(0), cnt_m1[IW-1:0]};
      end
      qse_pkg::OP_POP: begin
        sre = 1'b1;
      end
      qse_pkg::OP_RANGE: begin
        re0 = 1'b1;
        ra0 = stk_hi;
      end
      qse_pkg::OP_SCAN_RD: begin
        re0 = 1'b1;
        ra0 = j;
        re1 = 1'b1;
        ra1 = st;
      end
      qse_pkg::OP_FIN_RD: begin
        re1 = 1'b1;
        ra1 = st;
      end
      qse_pkg::OP_SW1: begin
        we = 1'b1;
        wa = st;
        wd = rd0;
      end
      qse_pkg::OP_SW2: begin
        we = 1'b1;
        wa = j;
        wd = rd1;
      end
      qse_pkg::OP_FIN1: begin
        we = 1'b1;
        wa = st;
        wd = pivot;
      end
      qse_pkg::OP_FIN2: begin
        we = 1'b1;
        wa = hi;
        wd = rd1;
      end
      qse_pkg::OP_PUSH_HI: begin
        swe = push_hi_ok;
        swd = {st_p1[IW-1:0], hi};
      end
      qse_pkg::OP_PUSH_LO: begin
        swe = push_lo_ok;
        swd = {lo, st_m1};
      end
      default: begin
      end
    endcase
  end

  // Element store: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re0) begin
      rd0 <= mem[ra0];
    end
    if (re1) begin
      rd1 <= mem[ra1];
    end
  end

  // Range stack: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (swe) begin
      stk[swa] <= swd;
    end
    if (sre) begin
      stk_rd <= stk[sra];
    end
  end

  // Control registers: count, pointers, phase and response valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rp        <= '0;
      sp        <= '0;
      draining  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (cmd.op)
        qse_pkg::OP_LOAD: begin
          count    <= eff_count + CW'(load_room);
          rp       <= '0;
          draining <= req.last;
        end
        qse_pkg::OP_FETCH: begin
          if (rp_p1 >= count) begin
            draining <= 1'b0;
            count    <= '0;
            rp       <= '0;
          end else begin
            rp <= rp_p1;
          end
        end
        qse_pkg::OP_FETCH_OUT: begin
          rsp_valid <= 1'b1;
        end
        qse_pkg::OP_SORT_INIT: begin
          sp <= (count >= CW'(2)) ? CW'(1) : '0;
        end
        qse_pkg::OP_POP: begin
          sp <= sp_m1;
        end
        qse_pkg::OP_PUSH_HI: begin
          if (push_hi_ok) begin
            sp <= sp + CW'(1);
          end
        end
        qse_pkg::OP_PUSH_LO: begin
          if (push_lo_ok) begin
            sp <= sp + CW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Partition registers and response payload.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      qse_pkg::OP_FETCH: begin
        last_pend <= (rp_p1 == count);
      end
      qse_pkg::OP_FETCH_OUT: begin
        rsp.value_res <= out_val;
        rsp.last_res  <= last_pend;
      end
      qse_pkg::OP_RANGE: begin
        lo <= stk_lo;
        hi <= stk_hi;
        j  <= stk_lo;
        st <= stk_lo;
      end
      qse_pkg::OP_PIVOT: begin
        pivot <= rd0;
      end
      qse_pkg::OP_CMP: begin
        if (!status.le) begin
          j <= j + IW'(1);
        end
      end
      qse_pkg::OP_SW2: begin
        st <= st + IW'(1);
        j  <= j + IW'(1);
      end
      default: begin
      end
    endcase
  end

endmodule

>>> sv/qse_ctrl.sv
// Controller state machine of the quicksort engine.
module qse_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  logic             req_action,
  input  logic             req_last,
  input  qse_pkg::status_t status,
  output qse_pkg::cmd_t    cmd
);

  qse_pkg::state_t state;
  qse_pkg::state_t state_next;
  logic            accept;

  // Words are taken only when idle and the output register is free or emptying.
  assign req_ready = (state == qse_pkg::ST_IDLE) && !status.rsp_valid;
  assign accept = req_valid && req_ready;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= qse_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      qse_pkg::ST_IDLE: begin
        if (accept) begin
          if (req_action == qse_pkg::ACT_LOAD) begin
            if (req_last) begin
              state_next = qse_pkg::ST_INIT;
            end
          end else if (status.fetch_pending) begin
            state_next = qse_pkg::ST_FETCH;
          end
        end
      end
      qse_pkg::ST_FETCH:   state_next = qse_pkg::ST_IDLE;
      qse_pkg::ST_INIT:    state_next = qse_pkg::ST_POP;
      qse_pkg::ST_POP: begin
        state_next = status.stack_empty ? qse_pkg::ST_IDLE : qse_pkg::ST_RANGE;
      end
      qse_pkg::ST_RANGE:   state_next = qse_pkg::ST_PIVOT;
      qse_pkg::ST_PIVOT:   state_next = qse_pkg::ST_SCAN;
      qse_pkg::ST_SCAN: begin
        state_next = status.scan_done ? qse_pkg::ST_FIN1 : qse_pkg::ST_CMP;
      end
      qse_pkg::ST_CMP: begin
        state_next = status.le ? qse_pkg::ST_SW1 : qse_pkg::ST_SCAN;
      end
      qse_pkg::ST_SW1:     state_next = qse_pkg::ST_SW2;
      qse_pkg::ST_SW2:     state_next = qse_pkg::ST_SCAN;
      qse_pkg::ST_FIN1:    state_next = qse_pkg::ST_FIN2;
      qse_pkg::ST_FIN2:    state_next = qse_pkg::ST_PUSH_HI;
      qse_pkg::ST_PUSH_HI: state_next = qse_pkg::ST_PUSH_LO;
      qse_pkg::ST_PUSH_LO: state_next = qse_pkg::ST_POP;
      default:             state_next = qse_pkg::ST_IDLE;
    endcase
  end

  // Datapath command for the current state.
  always_comb begin
    cmd.op = qse_pkg::OP_NONE;
    unique case (state)
      qse_pkg::ST_IDLE: begin
        if (accept) begin
          if (req_action == qse_pkg::ACT_LOAD) begin
            cmd.op = qse_pkg::OP_LOAD;
          end else if (status.fetch_pending) begin
            cmd.op = qse_pkg::OP_FETCH;
          end
        end
      end
      qse_pkg::ST_FETCH:   cmd.op = qse_pkg::OP_FETCH_OUT;
      qse_pkg::ST_INIT:    cmd.op = qse_pkg::OP_SORT_INIT;
      qse_pkg::ST_POP: begin
        if (!status.stack_empty) begin
          cmd.op = qse_pkg::OP_POP;
        end
      end
      qse_pkg::ST_RANGE:   cmd.op = qse_pkg::OP_RANGE;
      qse_pkg::ST_PIVOT:   cmd.op = qse_pkg::OP_PIVOT;
      qse_pkg::ST_SCAN: begin
        cmd.op = status.scan_done ? qse_pkg::OP_FIN_RD : qse_pkg::OP_SCAN_RD;
      end
      qse_pkg::ST_CMP:     cmd.op = qse_pkg::OP_CMP;
      qse_pkg::ST_SW1:     cmd.op = qse_pkg::OP_SW1;
      qse_pkg::ST_SW2:     cmd.op = qse_pkg::OP_SW2;
      qse_pkg::ST_FIN1:    cmd.op = qse_pkg::OP_FIN1;
      qse_pkg::ST_FIN2:    cmd.op = qse_pkg::OP_FIN2;
      qse_pkg::ST_PUSH_HI: cmd.op = qse_pkg::OP_PUSH_HI;
      qse_pkg::ST_PUSH_LO: cmd.op = qse_pkg::OP_PUSH_LO;
      default:             cmd.op = qse_pkg::OP_NONE;
    endcase
  end

endmodule

>>> sv/quicksort_engine.sv
// Top level of the quicksort engine: controller and datapath.
//
// Request channel (req_valid, req_ready, req): each word either loads one element
// (action clear) or fetches the next sorted element (action set). A load flagged last
// starts an ascending in-place quicksort of the loaded set; loads beyond DEPTH are
// dropped. Response channel (rsp_valid, rsp_ready, rsp) returns one word per fetch that
// has an element pending, the final element of the set flagged last_res.
// Loads may follow back to back. A fetch passes first through the registered element
// store read and then through the output register that holds the word.
// The sort after the flagged load keeps req_ready low for a data-dependent time set by
// the partition loop over the single write port of the element store: each range
// passes through the pop, range, pivot, finish and push states, each scanned element
// through a scan and a compare, and each swap through the swap states.
// While the receiver stalls, the output register holds its word and req_ready stays
// low until the word is taken or is being taken in the same cycle.
// Reset empties the set, the range stack and the output register at once; the element
// store and range stack need no clearing pass, as only written entries are read.
module quicksort_engine #(
  parameter int DEPTH      = qse_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = qse_pkg::DATA_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  qse_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output qse_pkg::rsp_t rsp
);

  qse_pkg::cmd_t    cmd;
  qse_pkg::status_t status;
  qse_pkg::status_t ctrl_status;

  // The controller sees the output register as free when its word is being taken.
  always_comb begin
    ctrl_status           = status;
    ctrl_status.rsp_valid = status.rsp_valid && !rsp_ready;
  end

  // Sequencer.
  qse_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req_action (req.action),
    .req_last   (req.last),
    .status     (ctrl_status),
    .cmd        (cmd)
  );

  // Storage and arithmetic.
  qse_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .status    (status),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready)
  );

endmodule
